@@ sv/bwc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwc_pkg
// shared types and constants for the binned weighted centroid block
// ----------------------------------------------------------------------------
package bwc_pkg;

  localparam int BIN_COUNT = 64;
  localparam int BIN_W     = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int SUM_W     = 64;
  localparam int CNT_W     = $clog2(SUM_W);
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_PER_UNIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_WEIGHT_MODE = 2'd2;

  typedef struct packed {
    logic signed [31:0] particle_x;
    logic signed [31:0] particle_y;
    logic signed [31:0] particle_z;
    logic        [15:0] particle_weight;
    logic               final_particle;
  } particle_t;

  typedef struct packed {
    logic        [5:0]  bin_number;
    logic signed [31:0] centroid_x;
    logic signed [31:0] centroid_y;
    logic               bin_empty;
    logic               final_bin;
  } result_t;

  // one bin of the store
  typedef struct packed {
    logic [SUM_W-1:0] w;
    logic [SUM_W-1:0] x;
    logic [SUM_W-1:0] y;
  } entry_t;

endpackage

@@ sv/bwc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwc_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module bwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/bwc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwc_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bwc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [bwc_pkg::SUM_W-1:0] dividend,
  input  logic [bwc_pkg::SUM_W-1:0] divisor,
  output logic                     done,
  output logic [bwc_pkg::SUM_W-1:0] quotient
);
  import bwc_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] dq;
  logic [SUM_W-1:0] dv;
  logic [SUM_W:0]   rem_sh;
  logic [SUM_W:0]   diff;
  logic             qbit;

  assign rem_sh   = {rem, dq[SUM_W-1]};
  assign diff     = rem_sh - {1'b0, dv};
  assign qbit     = ~diff[SUM_W];
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_W - 1);
        rem  <= '0;
        dq   <= dividend;
        dv   <= divisor;
      end else if (busy) begin
        rem <= qbit ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
        dq  <= {dq[SUM_W-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/binned_weighted_centroid_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binned_weighted_centroid_top
// bins particles by z, keeps saturating weight and moment sums per bin and
// reports each bin's weighted mean x and y on the final particle
// ----------------------------------------------------------------------------
//
//  channel   | signals                                   | beat taken when
//  ----------+-------------------------------------------+---------------------
//  particle  | start, busy, particle                     | start & ~busy
//  result    | result_strobe, result                     | result_strobe
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
//  a deposit keeps the block busy through the states mlo, mhi, bin, mx, my,
//  madd and mwr after the beat (only mlo to mx when the particle falls
//  outside the window); one shared 34x17 multiplier makes the two bin partial
//  products and then x*w and y*w, around a read-modify-write of the bin ram
//  the readout after a final particle walks every bin: an empty bin passes
//  rrd, rchk, rdec and emit; an occupied one also waits in rdx and rdy on
//  the bit-serial divider, which is run once for x and once for y
//  reset clears the state, the config registers and all bin valid bits at once,
//  so the store reads as zero straight away; no clearing pass is needed
//  results are strobed for one cycle each and cannot be stalled
//
module binned_weighted_centroid_top (
  input  logic                          clk,
  input  logic                          rst,
  // particle beats
  input  logic                          start,
  output logic                          busy,
  input  bwc_pkg::particle_t            particle,
  // result beats
  output logic                          result_strobe,
  output bwc_pkg::result_t              result,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import bwc_pkg::*;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MLO  = 4'd1;   // d * low half of scale
  localparam logic [3:0] S_MHI  = 4'd2;   // d * high half of scale
  localparam logic [3:0] S_BIN  = 4'd3;   // combine partials, pick bin
  localparam logic [3:0] S_MX   = 4'd4;   // x * w, read bin
  localparam logic [3:0] S_MY   = 4'd5;   // y * w, weight sum
  localparam logic [3:0] S_MADD = 4'd6;   // x moment sum
  localparam logic [3:0] S_MWR  = 4'd7;   // y moment sum, write back
  localparam logic [3:0] S_RRD  = 4'd8;   // readout: read bin k
  localparam logic [3:0] S_RCHK = 4'd9;   // readout: latch entry
  localparam logic [3:0] S_RDEC = 4'd10;  // readout: empty or divide
  localparam logic [3:0] S_RDX  = 4'd11;  // wait for x quotient
  localparam logic [3:0] S_RDY  = 4'd12;  // wait for y quotient
  localparam logic [3:0] S_EMIT = 4'd13;  // result beat

  localparam logic [SUM_W-1:0] S64_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] S64_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // saturating signed add of two moment sums
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? S64_MIN : S64_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

  // clamp a quotient magnitude into signed q8.24 and restore the sign
  function automatic logic [31:0] sat_mean(input logic [SUM_W-1:0] q,
                                           input logic neg);
    logic [31:0] m;
    if (neg) begin
      m = (q > SUM_W'(64'h8000_0000)) ? 32'h8000_0000 : q[31:0];
      return ~m + 32'd1;
    end
    return (q > SUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  logic [3:0]          state;

  // config registers
  logic signed [31:0]  window_start;
  logic [31:0]         bins_per_unit;
  logic                unit_weight_mode;

  // particle working registers
  particle_t           par;
  logic [32:0]         d;          // z - window_start, exact
  logic [16:0]         w17;        // weight, zero extended
  logic [32:0]         lo_part;
  logic [BIN_W-1:0]    bin_idx;
  logic                keep;
  logic signed [50:0]  prod;
  logic [SUM_W-1:0]    px;
  logic [SUM_W-1:0]    py;
  logic [SUM_W-1:0]    old_x;
  logic [SUM_W-1:0]    old_y;
  logic [SUM_W-1:0]    new_w;
  logic [SUM_W-1:0]    new_x;

  // shared multiplier
  logic signed [33:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [50:0]  mul_p;

  // bin store
  logic [BIN_COUNT-1:0] valid;
  logic                ram_we;
  logic                ram_re;
  logic [BIN_W-1:0]    ram_raddr;
  entry_t              ram_wdata;
  entry_t              ram_rdata;

  // readout
  logic [BIN_W-1:0]    k;
  logic [SUM_W-1:0]    ent_w;
  logic [SUM_W-1:0]    ent_x;
  logic [SUM_W-1:0]    ent_y;
  logic [SUM_W-1:0]    mag_x;
  logic [SUM_W-1:0]    mag_y;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_quot;
  result_t             res;

  logic [49:0]         binsum;
  logic [25:0]         bin_full;
  logic [SUM_W:0]      wsum;
  logic                k_last;

  assign busy          = (state != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign result_strobe = (state == S_EMIT);
  assign result        = res;

  // configuration writes, taken whenever offered
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start     <= '0;
      bins_per_unit    <= 32'd65536;
      unit_weight_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_START:     window_start     <= cfg_data;
        REG_BINS_PER_UNIT:    bins_per_unit    <= cfg_data;
        REG_UNIT_WEIGHT_MODE: unit_weight_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // operand selection for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MLO: begin
        mul_a = {d[32], d};
        mul_b = {1'b0, bins_per_unit[15:0]};
      end
      S_MHI: begin
        mul_a = {d[32], d};
        mul_b = {1'b0, bins_per_unit[31:16]};
      end
      S_MX: begin
        mul_a = {{2{par.particle_x[31]}}, par.particle_x};
        mul_b = w17;
      end
      S_MY: begin
        mul_a = {{2{par.particle_y[31]}}, par.particle_y};
        mul_b = w17;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // floor(d * scale / 2^40) from the two partial products
  assign binsum   = prod[49:0] + {17'b0, lo_part};
  assign bin_full = binsum[49:24];
  assign wsum     = {1'b0, (valid[bin_idx] ? ram_rdata.w : '0)}
                  + {{(SUM_W-16){1'b0}}, w17[15:0]};

  assign mag_x  = ent_x[SUM_W-1] ? (~ent_x + 1'b1) : ent_x;
  assign mag_y  = ent_y[SUM_W-1] ? (~ent_y + 1'b1) : ent_y;
  assign k_last = (k == BIN_W'(BIN_COUNT - 1));

  assign div_start = ((state == S_RDEC) && (ent_w != '0))
                   || ((state == S_RDX) && div_done);

  assign ram_re    = (state == S_MX && keep) || (state == S_RRD);
  assign ram_raddr = (state == S_MX) ? bin_idx : k;
  assign ram_we    = (state == S_MWR);
  assign ram_wdata = '{w: new_w, x: new_x, y: sat_add(old_y, py)};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_MLO;
          end
        end
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_BIN;
        S_BIN:  state <= S_MX;
        S_MX: begin
          if (keep) begin
            state <= S_MY;
          end else begin
            state <= par.final_particle ? S_RRD : S_IDLE;
          end
        end
        S_MY:   state <= S_MADD;
        S_MADD: state <= S_MWR;
        S_MWR: begin
          valid[bin_idx] <= 1'b1;
          state <= par.final_particle ? S_RRD : S_IDLE;
        end
        S_RRD:  state <= S_RCHK;
        S_RCHK: state <= S_RDEC;
        S_RDEC: state <= (ent_w == '0) ? S_EMIT : S_RDX;
        S_RDX: begin
          if (div_done) begin
            state <= S_RDY;
          end
        end
        S_RDY: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (k_last) begin
            valid <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_RRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    case (state)
      S_IDLE: begin
        par <= particle;
        d   <= {particle.particle_z[31], particle.particle_z}
             - {window_start[31], window_start};
        w17 <= unit_weight_mode ? 17'd1 : {1'b0, particle.particle_weight};
        k   <= '0;
      end
      S_MHI: lo_part <= prod[48:16];
      S_BIN: begin
        // zero scale puts everything in bin zero
        keep    <= (bins_per_unit == '0)
                || (!d[32] && (bin_full < 26'(BIN_COUNT)));
        bin_idx <= (bins_per_unit == '0) ? '0 : bin_full[BIN_W-1:0];
      end
      S_MY: begin
        px    <= {{(SUM_W-51){prod[50]}}, prod};
        old_x <= valid[bin_idx] ? ram_rdata.x : '0;
        old_y <= valid[bin_idx] ? ram_rdata.y : '0;
        new_w <= wsum[SUM_W] ? {SUM_W{1'b1}} : wsum[SUM_W-1:0];
      end
      S_MADD: begin
        py    <= {{(SUM_W-51){prod[50]}}, prod};
        new_x <= sat_add(old_x, px);
      end
      S_RCHK: begin
        ent_w <= valid[k] ? ram_rdata.w : '0;
        ent_x <= valid[k] ? ram_rdata.x : '0;
        ent_y <= valid[k] ? ram_rdata.y : '0;
      end
      S_RDEC: begin
        res.bin_number <= 6'(k);
        res.final_bin  <= k_last;
        res.bin_empty  <= (ent_w == '0);
        res.centroid_x <= '0;
        res.centroid_y <= '0;
      end
      S_RDX: begin
        if (div_done) begin
          res.centroid_x <= sat_mean(div_quot, ent_x[SUM_W-1]);
        end
      end
      S_RDY: begin
        if (div_done) begin
          res.centroid_y <= sat_mean(div_quot, ent_y[SUM_W-1]);
        end
      end
      S_EMIT: k <= k + 1'b1;
      default: ;
    endcase
  end

  bwc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(BIN_COUNT)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(bin_idx),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bwc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend((state == S_RDEC) ? mag_x : mag_y),
    .divisor (ent_w),
    .done    (div_done),
    .quotient(div_quot)
  );

  // a taken particle beat holds the block busy for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after particle beat");

  // results only appear inside a readout run
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result strobe while idle");

  // each result beat is a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("result strobe held for two cycles");

  // an empty bin reports zero means
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.bin_empty) |->
      (result.centroid_x == '0 && result.centroid_y == '0))
    else $error("empty bin with non-zero centroid");

  // the last bin of a run returns the block to idle
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.final_bin) |=> !busy)
    else $error("block still busy after last bin");

endmodule
